/* rtl/core/rtt_pkg.sv */
package rtt_pkg;

  // Table geometry. Tag 0 is reserved, so tags run from 1 to TABLE_SLOTS-1.
  localparam int unsigned TABLE_SLOTS = 8192;
  localparam int unsigned IDX_W       = $clog2(TABLE_SLOTS);
  localparam int unsigned GIVEN_W     = 13;
  localparam logic [IDX_W:0] SLOTS_X  = (IDX_W + 1)'(TABLE_SLOTS);

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_REPLY  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_CANCELLED = 3'd1,
    ST_DELIVERED = 3'd2,
    ST_BAD_TAG   = 3'd3,
    ST_ZERO_TAG  = 3'd4,
    ST_OVERLAP   = 3'd5,
    ST_NO_WAITER = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] requester;
    logic [31:0] object_id;
    logic [31:0] tag;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [GIVEN_W-1:0] given_tag;
    logic [15:0]        deliver_to;
    logic               first_zero_warning;
  } out_item_t;

  // One table entry as it sits in the slot memory.
  typedef struct packed {
    logic        valid;
    logic [15:0] requester;
    logic [31:0] object_id;
  } slot_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic clear_en;
    logic lookup;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;
    logic needs_lookup;
    logic has_result;
  } dp_sts_t;

endpackage

/* rtl/core/rtt_ram.sv */
module rtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/rtt_datapath.sv */
module rtt_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  rtt_pkg::in_item_t in_item,
  input  rtt_pkg::dp_cmd_t  cmd,
  output rtt_pkg::dp_sts_t  sts,
  output rtt_pkg::out_item_t out_item
);
  import rtt_pkg::*;

  logic [IDX_W-1:0] last_tag_r, last_tag_nxt;
  logic [IDX_W-1:0] clr_cnt_r;
  logic             zero_warned_r, zero_warned_nxt;
  logic [31:0]      obj_r;
  out_item_t        res_r;

  logic [IDX_W:0]   inc;
  logic [IDX_W-1:0] next_tag;
  logic [IDX_W-1:0] tag_idx;
  logic             tag_in_range;
  logic             tag_zero;
  logic             is_alloc, is_cancel, is_reply;
  out_item_t        imm_res;
  out_item_t        look_res;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_slot;
  slot_t            rd_slot;
  logic [$bits(slot_t)-1:0] rd_bits;

  assign is_alloc  = (in_item.kind == KIND_ALLOC);
  assign is_cancel = (in_item.kind == KIND_CANCEL);
  assign is_reply  = (in_item.kind == KIND_REPLY);

  assign tag_in_range = (in_item.tag < 32'(TABLE_SLOTS));
  assign tag_zero     = (in_item.tag == 32'd0);
  assign tag_idx      = in_item.tag[IDX_W-1:0];

  // Next tag wraps from the table size back to 1.
  assign inc      = {1'b0, last_tag_r} + (IDX_W + 1)'(1);
  assign next_tag = (inc >= SLOTS_X) ? IDX_W'(1) : inc[IDX_W-1:0];

  always_comb begin
    imm_res         = '0;
    imm_res.status  = ST_ALLOCATED;
    last_tag_nxt    = last_tag_r;
    zero_warned_nxt = zero_warned_r;
    if (is_alloc) begin
      imm_res.status    = ST_ALLOCATED;
      imm_res.given_tag = GIVEN_W'(next_tag);
      last_tag_nxt      = next_tag;
    end else if (is_cancel) begin
      imm_res.status = (tag_in_range && !tag_zero) ? ST_CANCELLED : ST_BAD_TAG;
    end else if (is_reply) begin
      priority if (!tag_in_range) begin
        imm_res.status = ST_BAD_TAG;
      end else if (tag_zero) begin
        imm_res.status             = ST_ZERO_TAG;
        imm_res.first_zero_warning = !zero_warned_r;
        zero_warned_nxt            = 1'b1;
      end else begin
        imm_res.status = ST_NO_WAITER;
      end
    end
  end

  assign sts.needs_lookup = is_reply && tag_in_range && !tag_zero;
  assign sts.has_result   = (is_alloc || is_cancel || is_reply) && !sts.needs_lookup;
  assign sts.clear_last   = (clr_cnt_r == IDX_W'(TABLE_SLOTS - 1));

  // Slot memory write port: clearing pass, allocate, or cancel.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tag_idx;
    wr_slot = '0;
    if (cmd.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
    end else if (cmd.accept && is_alloc) begin
      wr_en             = 1'b1;
      wr_addr           = next_tag;
      wr_slot.valid     = 1'b1;
      wr_slot.requester = in_item.requester;
      wr_slot.object_id = in_item.object_id;
    end else if (cmd.accept && is_cancel && tag_in_range && !tag_zero) begin
      wr_en = 1'b1;
    end
  end

  rtt_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_en   (cmd.accept && sts.needs_lookup),
    .rd_addr (tag_idx),
    .rd_data (rd_bits)
  );

  assign rd_slot = slot_t'(rd_bits);

  always_comb begin
    look_res = '0;
    priority if (!rd_slot.valid) begin
      look_res.status = ST_NO_WAITER;
    end else if (rd_slot.object_id != obj_r) begin
      look_res.status = ST_OVERLAP;
    end else begin
      look_res.status     = ST_DELIVERED;
      look_res.deliver_to = rd_slot.requester;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tag_r    <= '0;
      zero_warned_r <= 1'b0;
      clr_cnt_r     <= '0;
    end else begin
      if (cmd.accept) begin
        last_tag_r    <= last_tag_nxt;
        zero_warned_r <= zero_warned_nxt;
      end
      if (cmd.clear_en) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      obj_r <= in_item.object_id;
      res_r <= imm_res;
    end else if (cmd.lookup) begin
      res_r <= look_res;
    end
  end

  assign out_item = res_r;

endmodule

/* rtl/core/rtt_ctrl.sv */
module rtt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rtt_pkg::dp_sts_t sts,
  output rtt_pkg::dp_cmd_t cmd
);
  import rtt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = !out_valid_r || out_ready;
        cmd.accept = in_valid && in_ready;
        if (cmd.accept) begin
          if (sts.needs_lookup) begin
            state_nxt = S_LOOKUP;
          end else if (sts.has_result) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_LOOKUP: begin
        cmd.lookup    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/request_tag_tracker.sv */
// Request tag tracker: hands out request tags and matches replies to them.
// The input channel (in_valid, in_ready, in_item) carries one item per
// request: an allocate, a cancel or a reply. The result channel (out_valid,
// out_ready, out_item) returns one item for each allocate, cancel or reply;
// an item of the unused kind is taken and produces nothing.
// Allocates, cancels and replies with a bad or zero tag need no lookup:
// the result is valid the cycle after the item is taken, and the next item
// can be taken in that same cycle if the receiver is ready. A reply that
// must look up its slot passes through the registered slot memory read and
// a compare that loads the result, and takes no new item during the lookup.
// The rate is one item per cycle for other traffic while the receiver is ready.
// After reset the block sweeps the slot memory to clear every valid bit,
// one entry per cycle, over all TABLE_SLOTS (8192) entries; in_ready stays
// low during the sweep. The tag counter and the zero-tag warning flag clear
// at once.
// When the receiver stalls, the result stays in the output register and
// in_ready drops until that item is taken, so no item is lost.
module request_tag_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rtt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rtt_pkg::out_item_t out_item
);
  import rtt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences the clearing sweep, item acceptance and the
  // lookup cycle, and owns the result valid flag.
  rtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the tag counter, the slot memory and the result
  // register.
  rtt_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

/* rtl/core/rtt_checker.sv */
module rtt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input rtt_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input rtt_pkg::out_item_t out_item
);
  import rtt_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // The clearing sweep keeps the input closed right after reset.
  a_reset_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open right after reset");

  // An allocate never gives out tag zero.
  a_alloc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_ALLOCATED |-> out_item.given_tag != '0)
    else $error("tag zero allocated");

  // Only allocates carry a tag, only deliveries carry a requester.
  a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_ALLOCATED |->
      out_item.given_tag == '0 &&
      (out_item.status == ST_DELIVERED || out_item.deliver_to == '0))
    else $error("stray field in result");

  // The warning flag comes only with a zero-tag result.
  a_warn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.first_zero_warning |-> out_item.status == ST_ZERO_TAG)
    else $error("warning without zero tag");

endmodule

bind request_tag_tracker rtt_checker u_rtt_checker (.*);
